/* sv/bbc_pkg.sv */
// ----------------------------------------------------------------------------
// bbc_pkg: shared types and constants for the bracket balance checker
// Request and status codes, bracket codes, sizes and the classified-beat type.
// ----------------------------------------------------------------------------
`default_nettype none

package bbc_pkg;

  // Bracket stack depth and derived widths
  localparam int STACK_DEPTH = 64;
  localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
  localparam int ADDR_W      = $clog2(STACK_DEPTH);

  // Line counter, saturating
  localparam int LINE_BITS = 24;
  localparam logic [LINE_BITS-1:0] LINE_MAX = '1;

  // Front-to-back queue (power of two)
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

  // Request types
  localparam logic [1:0] REQ_CHAR = 2'd0;
  localparam logic [1:0] REQ_EOL  = 2'd1;
  localparam logic [1:0] REQ_EOF  = 2'd2;

  // Result status codes
  localparam logic [2:0] ST_RUN      = 3'd0;
  localparam logic [2:0] ST_OK       = 3'd1;
  localparam logic [2:0] ST_NO_OPEN  = 3'd2;
  localparam logic [2:0] ST_MISMATCH = 3'd3;
  localparam logic [2:0] ST_UNCLOSED = 3'd4;
  localparam logic [2:0] ST_OVERFLOW = 3'd5;

  // Bracket kind codes held on the stack
  localparam logic [1:0] BR_CURLY  = 2'd0;
  localparam logic [1:0] BR_SQUARE = 2'd1;
  localparam logic [1:0] BR_PAREN  = 2'd2;

  // Characters of interest
  localparam logic [7:0] CH_LBRACE = 8'h7B;
  localparam logic [7:0] CH_LBRACK = 8'h5B;
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RBRACE = 8'h7D;
  localparam logic [7:0] CH_RBRACK = 8'h5D;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_QUOTE  = 8'h22;

  // One classified beat as it travels from front to back
  typedef struct packed {
    logic [1:0] req;
    logic       is_quote;
    logic       is_slash;
    logic       is_star;
    logic       is_open;
    logic       is_close;
    logic [1:0] code;
  } bbc_item_t;

  function automatic logic [7:0] closer_char(input logic [1:0] code);
    logic [7:0] c;
    case (code)
      BR_CURLY:  c = CH_RBRACE;
      BR_SQUARE: c = CH_RBRACK;
      BR_PAREN:  c = CH_RPAREN;
      default:   c = CH_RBRACE;
    endcase
    return c;
  endfunction

endpackage

`default_nettype wire

/* sv/bracket_balance_checker.sv */
// ----------------------------------------------------------------------------
// bracket_balance_checker: streaming bracket balance checker
// Scans source text beats, tracks comments and quotes, and checks {} [] ().
// ----------------------------------------------------------------------------
//
//   channel  direction  handshake             payload
//   -------  ---------  --------------------  ---------------------------------
//   in       sink       in_valid / in_ready   req_type, char_in
//   out      source     out_valid / out_ready status, expected_char,
//                                             found_char, line_number
//
// One beat per clock unless the output stalls; one result beat per input beat.
// An accepted beat waits in the front queue and its result is registered when
// the back end pops it from the queue.
// In the back end the stack top and the entry under it live in flops, the
// deeper entries in a 1-write/1-read memory.
// Synchronous reset clears all control state; the stack memory is not cleared
// and needs no clearing pass (only written entries are ever read).
// A stalled output holds its beat; the queue absorbs up to two beats, then
// in_ready drops until the back end drains.
// ----------------------------------------------------------------------------
`default_nettype none

module bracket_balance_checker (
  input  wire logic                             clk,
  input  wire logic                             rst,
  // input channel
  input  wire logic                             in_valid,
  output logic                                  in_ready,
  input  wire logic [1:0]                       req_type,
  input  wire logic [7:0]                       char_in,
  // result channel
  output logic                                  out_valid,
  input  wire logic                             out_ready,
  output logic [2:0]                            status,
  output logic [7:0]                            expected_char,
  output logic [7:0]                            found_char,
  output logic [bbc_pkg::LINE_BITS-1:0]         line_number
);

  bbc_pkg::bbc_item_t push_item;
  bbc_pkg::bbc_item_t pop_item;
  logic               q_push;
  logic               q_full;
  logic               q_pop;
  logic               q_valid;

  // Front: accept and classify each character
  bbc_front u_front (
    .in_valid (in_valid),
    .in_ready (in_ready),
    .req_type (req_type),
    .char_in  (char_in),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_item   (push_item)
  );

  // Decoupling queue between classification and execution
  bbc_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_item (push_item),
    .full      (q_full),
    .pop       (q_pop),
    .not_empty (q_valid),
    .pop_item  (pop_item)
  );

  // Back: scanner state, bracket stack, result register
  bbc_back u_back (
    .clk           (clk),
    .rst           (rst),
    .q_valid       (q_valid),
    .item          (pop_item),
    .q_pop         (q_pop),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .status        (status),
    .expected_char (expected_char),
    .found_char    (found_char),
    .line_number   (line_number)
  );

endmodule

`default_nettype wire

/* sv/bbc_front.sv */
// ----------------------------------------------------------------------------
// bbc_front: input acceptance and character classification
// Decodes each incoming beat into bracket/comment/quote flags for the back end.
// ----------------------------------------------------------------------------
`default_nettype none

module bbc_front (
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire logic [1:0]        req_type,
  input  wire logic [7:0]        char_in,
  input  wire logic              q_full,
  output logic                   q_push,
  output bbc_pkg::bbc_item_t     q_item
);

  assign in_ready = !q_full;
  assign q_push   = in_valid && !q_full;

  always_comb begin
    q_item          = '0;
    q_item.req      = req_type;
    q_item.is_quote = (char_in == bbc_pkg::CH_QUOTE);
    q_item.is_slash = (char_in == bbc_pkg::CH_SLASH);
    q_item.is_star  = (char_in == bbc_pkg::CH_STAR);
    case (char_in)
      bbc_pkg::CH_LBRACE: begin
        q_item.is_open = 1'b1;
        q_item.code    = bbc_pkg::BR_CURLY;
      end
      bbc_pkg::CH_LBRACK: begin
        q_item.is_open = 1'b1;
        q_item.code    = bbc_pkg::BR_SQUARE;
      end
      bbc_pkg::CH_LPAREN: begin
        q_item.is_open = 1'b1;
        q_item.code    = bbc_pkg::BR_PAREN;
      end
      bbc_pkg::CH_RBRACE: begin
        q_item.is_close = 1'b1;
        q_item.code     = bbc_pkg::BR_CURLY;
      end
      bbc_pkg::CH_RBRACK: begin
        q_item.is_close = 1'b1;
        q_item.code     = bbc_pkg::BR_SQUARE;
      end
      bbc_pkg::CH_RPAREN: begin
        q_item.is_close = 1'b1;
        q_item.code     = bbc_pkg::BR_PAREN;
      end
      default: begin
      end
    endcase
  end

endmodule

`default_nettype wire

/* sv/bbc_queue.sv */
// ----------------------------------------------------------------------------
// bbc_queue: short FIFO between front and back
// Holds classified beats so the front and back can stall independently.
// ----------------------------------------------------------------------------
`default_nettype none

module bbc_queue (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               push,
  input  wire bbc_pkg::bbc_item_t push_item,
  output logic                    full,
  input  wire logic               pop,
  output logic                    not_empty,
  output bbc_pkg::bbc_item_t      pop_item
);

  bbc_pkg::bbc_item_t               slots [bbc_pkg::QUEUE_DEPTH];
  logic [bbc_pkg::QPTR_W-1:0]       wr_ptr;
  logic [bbc_pkg::QPTR_W-1:0]       rd_ptr;
  logic [bbc_pkg::QPTR_W:0]         fill;

  assign full      = (fill == (bbc_pkg::QPTR_W+1)'(bbc_pkg::QUEUE_DEPTH));
  assign not_empty = (fill != '0);
  assign pop_item  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        fill <= fill + 1'b1;
      end else if (pop && !push) begin
        fill <= fill - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

/* sv/bbc_back.sv */
// ----------------------------------------------------------------------------
// bbc_back: comment/quote tracking, bracket stack and result register
// Executes one classified beat per cycle unless stalled; one result per beat.
// ----------------------------------------------------------------------------
`default_nettype none

module bbc_back (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            q_valid,
  input  wire bbc_pkg::bbc_item_t              item,
  output logic                                 q_pop,
  output logic                                 out_valid,
  input  wire logic                            out_ready,
  output logic [2:0]                           status,
  output logic [7:0]                           expected_char,
  output logic [7:0]                           found_char,
  output logic [bbc_pkg::LINE_BITS-1:0]        line_number
);

  // Stack: top two entries in flops, the rest in a memory
  logic [bbc_pkg::CNT_W-1:0]     count, count_next;
  logic [1:0]                    top_code, top_next;
  logic [1:0]                    below_code, below_next;
  logic [1:0]                    mem [bbc_pkg::STACK_DEPTH];
  logic [1:0]                    mem_rd;
  logic [1:0]                    fwd_data;
  logic                          fwd_hit;
  logic                          mem_we;
  logic [bbc_pkg::ADDR_W-1:0]    wr_addr, rd_addr;
  logic [bbc_pkg::CNT_W-1:0]     cnt_m2, cnt_m3;
  logic [1:0]                    below_src;

  // Scanner state
  logic                          prev_slash, prev_slash_next;
  logic                          prev_star, prev_star_next;
  logic                          lc, lc_next;
  logic                          qa, qa_next;
  logic                          bc, bc_next;
  logic                          lc_mid, qa_mid, bc_mid;
  logic                          live;
  logic [2:0]                    err, err_next;
  logic [7:0]                    lat_exp, lat_exp_next;
  logic [7:0]                    lat_fnd, lat_fnd_next;
  logic [bbc_pkg::LINE_BITS-1:0] line_cnt, line_cnt_next;

  // Result fields for the beat being executed
  logic [2:0]                    res_status;
  logic [7:0]                    res_exp, res_fnd;
  logic [bbc_pkg::LINE_BITS-1:0] res_line;

  logic stack_full, stack_empty;

  assign q_pop       = q_valid && (!out_valid || out_ready);
  assign stack_full  = (count == bbc_pkg::CNT_W'(bbc_pkg::STACK_DEPTH));
  assign stack_empty = (count == '0);
  assign cnt_m2      = count - bbc_pkg::CNT_W'(2);
  assign cnt_m3      = count_next - bbc_pkg::CNT_W'(3);
  assign wr_addr     = cnt_m2[bbc_pkg::ADDR_W-1:0];
  assign rd_addr     = cnt_m3[bbc_pkg::ADDR_W-1:0];
  assign below_src   = fwd_hit ? fwd_data : mem_rd;

  // Comment and quote flags after this character
  always_comb begin
    qa_mid = qa;
    lc_mid = lc;
    bc_mid = bc;
    if (item.is_quote && !lc && !bc) begin
      qa_mid = !qa;
    end else if (!qa && !lc && !bc && prev_slash && item.is_slash) begin
      lc_mid = 1'b1;
    end else if (!qa && !lc && !bc && prev_slash && item.is_star) begin
      bc_mid = 1'b1;
    end else if (bc && prev_star && item.is_slash) begin
      bc_mid = 1'b0;
    end
  end

  assign live = !qa_mid && !lc_mid && !bc_mid;

  always_comb begin
    count_next      = count;
    top_next        = top_code;
    below_next      = below_code;
    prev_slash_next = prev_slash;
    prev_star_next  = prev_star;
    lc_next         = lc;
    qa_next         = qa;
    bc_next         = bc;
    err_next        = err;
    lat_exp_next    = lat_exp;
    lat_fnd_next    = lat_fnd;
    line_cnt_next   = line_cnt;
    mem_we          = 1'b0;
    res_status      = bbc_pkg::ST_RUN;
    res_exp         = '0;
    res_fnd         = '0;
    res_line        = '0;
    if (q_pop) begin
      case (item.req)
        bbc_pkg::REQ_CHAR: begin
          if (err == bbc_pkg::ST_RUN) begin
            qa_next         = qa_mid;
            lc_next         = lc_mid;
            bc_next         = bc_mid;
            prev_slash_next = item.is_slash;
            prev_star_next  = item.is_star;
            if (live && item.is_open) begin
              if (stack_full) begin
                err_next = bbc_pkg::ST_OVERFLOW;
              end else begin
                mem_we     = (count >= bbc_pkg::CNT_W'(2));
                below_next = top_code;
                top_next   = item.code;
                count_next = count + 1'b1;
              end
            end else if (live && item.is_close) begin
              if (stack_empty) begin
                err_next     = bbc_pkg::ST_NO_OPEN;
                lat_fnd_next = bbc_pkg::closer_char(item.code);
              end else if (top_code == item.code) begin
                top_next   = below_code;
                below_next = below_src;
                count_next = count - 1'b1;
              end else begin
                err_next     = bbc_pkg::ST_MISMATCH;
                lat_exp_next = bbc_pkg::closer_char(top_code);
                lat_fnd_next = bbc_pkg::closer_char(item.code);
              end
            end
          end
        end
        bbc_pkg::REQ_EOL: begin
          if (err == bbc_pkg::ST_RUN) begin
            prev_slash_next = 1'b0;
            prev_star_next  = 1'b0;
            lc_next         = 1'b0;
            qa_next         = 1'b0;
            if (line_cnt != bbc_pkg::LINE_MAX) begin
              line_cnt_next = line_cnt + 1'b1;
            end
          end
        end
        bbc_pkg::REQ_EOF: begin
          res_line = line_cnt;
          if (err != bbc_pkg::ST_RUN) begin
            res_status = err;
            res_exp    = lat_exp;
            res_fnd    = lat_fnd;
          end else if (stack_empty) begin
            res_status = bbc_pkg::ST_OK;
            res_line   = '0;
          end else begin
            res_status = bbc_pkg::ST_UNCLOSED;
            res_exp    = bbc_pkg::closer_char(top_code);
          end
          // back to the reset state
          count_next      = '0;
          prev_slash_next = 1'b0;
          prev_star_next  = 1'b0;
          lc_next         = 1'b0;
          qa_next         = 1'b0;
          bc_next         = 1'b0;
          err_next        = bbc_pkg::ST_RUN;
          lat_exp_next    = '0;
          lat_fnd_next    = '0;
          line_cnt_next   = '0;
        end
        default: begin
        end
      endcase
    end
  end

  // Stack memory; read address tracks the entry under the below register.
  // A push writes exactly that entry, so the write data is forwarded.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[wr_addr] <= below_code;
    end
    mem_rd   <= mem[rd_addr];
    fwd_data <= below_code;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fwd_hit <= 1'b0;
    end else begin
      fwd_hit <= mem_we && (wr_addr == rd_addr);
    end
  end

  always_ff @(posedge clk) begin
    top_code   <= top_next;
    below_code <= below_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count      <= '0;
      prev_slash <= 1'b0;
      prev_star  <= 1'b0;
      lc         <= 1'b0;
      qa         <= 1'b0;
      bc         <= 1'b0;
      err        <= bbc_pkg::ST_RUN;
      lat_exp    <= '0;
      lat_fnd    <= '0;
      line_cnt   <= '0;
      out_valid  <= 1'b0;
    end else begin
      count      <= count_next;
      prev_slash <= prev_slash_next;
      prev_star  <= prev_star_next;
      lc         <= lc_next;
      qa         <= qa_next;
      bc         <= bc_next;
      err        <= err_next;
      lat_exp    <= lat_exp_next;
      lat_fnd    <= lat_fnd_next;
      line_cnt   <= line_cnt_next;
      if (q_pop) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      status        <= res_status;
      expected_char <= res_exp;
      found_char    <= res_fnd;
      line_number   <= res_line;
    end
  end

endmodule

`default_nettype wire

/* sv/bbc_checker.sv */
// ----------------------------------------------------------------------------
// bbc_checker: port-level checks for the bracket balance checker
// Watches the result channel and is bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module bbc_checker (
  input wire logic                        clk,
  input wire logic                        rst,
  input wire logic                        out_valid,
  input wire logic                        out_ready,
  input wire logic [2:0]                  status,
  input wire logic [7:0]                  expected_char,
  input wire logic [7:0]                  found_char,
  input wire logic [bbc_pkg::LINE_BITS-1:0] line_number
);

  // Held result beat stays put under backpressure
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(status) &&
      $stable(expected_char) && $stable(found_char) && $stable(line_number))
    else $error("result beat changed while stalled");

  // No result right after reset
  a_rst: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid after reset");

  // Running and clean-finish results carry no detail
  a_quiet: assert property (@(posedge clk) disable iff (rst)
    out_valid && (status == bbc_pkg::ST_RUN || status == bbc_pkg::ST_OK) |->
      expected_char == '0 && found_char == '0 && line_number == '0)
    else $error("detail fields set on a non-error result");

  // Missing opener never names an expected closer; unclosed never a found one
  a_detail: assert property (@(posedge clk) disable iff (rst)
    out_valid && (status == bbc_pkg::ST_NO_OPEN || status == bbc_pkg::ST_UNCLOSED) |->
      ((status == bbc_pkg::ST_NO_OPEN) ? (expected_char == '0 && found_char != '0)
                                       : (found_char == '0 && expected_char != '0)))
    else $error("inconsistent error detail");

  // Status stays within the defined codes
  a_code: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> status <= bbc_pkg::ST_OVERFLOW)
    else $error("undefined status code");

endmodule

bind bracket_balance_checker bbc_checker u_bbc_checker (
  .clk           (clk),
  .rst           (rst),
  .out_valid     (out_valid),
  .out_ready     (out_ready),
  .status        (status),
  .expected_char (expected_char),
  .found_char    (found_char),
  .line_number   (line_number)
);

`default_nettype wire
